// ===== src/scid_pkg.sv =====
package scid_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned DIGIT_DEPTH = 10;
  localparam int unsigned CNT_W       = 4;

  // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;
  localparam int unsigned        QUOT_W      = 2*VALUE_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef struct packed {
    logic load;        // capture magnitude and sign
    logic mul;         // reciprocal multiply into product register
    logic div;         // take quotient, push remainder digit
    logic pop;         // drop top digit after it was sent
    logic sign_phase;  // output shows the minus sign
  } scid_cmd_t;

  typedef struct packed {
    logic q_zero;
    logic neg;
    logic cnt_one;
  } scid_status_t;

endpackage

// ===== src/scid_ifs.sv =====
interface scid_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface scid_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== src/scid_ctrl.sv =====
module scid_ctrl import scid_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  scid_status_t status,
  output scid_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (status.q_zero) begin
          state_next = status.neg ? ST_SIGN : ST_EMIT;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_SIGN: begin
        out_valid      = 1'b1;
        cmd.sign_phase = 1'b1;
        if (out_ready) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.pop = 1'b1;
          if (status.cnt_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output active together");

  a_sign_then_digit: assert property (@(posedge clk) disable iff (rst)
    (cmd.sign_phase && out_ready) |=> (out_valid && !cmd.sign_phase))
    else $error("minus sign not followed by a digit");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped before transaction");

endmodule

// ===== src/scid_dp.sv =====
module scid_dp import scid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  scid_cmd_t            cmd,
  input  logic [VALUE_W-1:0]   value,
  output scid_status_t         status,
  output logic [CHAR_W-1:0]    char_code,
  output logic                 last_char
);

  logic [VALUE_W-1:0]   mag;
  logic                 neg;
  logic [2*VALUE_W-1:0] prod;
  logic [DIGIT_W-1:0]   stack [DIGIT_DEPTH];
  logic [CNT_W-1:0]     cnt;

  logic [QUOT_W-1:0]    quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   rem_full;
  logic [DIGIT_W-1:0]   digit;

  assign quot     = prod[2*VALUE_W-1:RECIP_SHIFT];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = mag - quot_x10;
  assign digit    = rem_full[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[VALUE_W-1];
      mag <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
    end else if (cmd.div) begin
      mag <= {{(VALUE_W-QUOT_W){1'b0}}, quot};
    end
    if (cmd.mul) begin
      prod <= mag * RECIP10;
    end
  end

  // digit stack: pushed least significant first, so the top is the leading digit
  always_ff @(posedge clk) begin
    if (cmd.div) begin
      stack[0] <= digit;
      for (int i = 1; i < DIGIT_DEPTH; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < DIGIT_DEPTH - 1; i++) begin
        stack[i] <= stack[i+1];
      end
      stack[DIGIT_DEPTH-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.div) begin
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign status.q_zero  = (quot == '0);
  assign status.neg     = neg;
  assign status.cnt_one = (cnt == CNT_W'(1));

  assign char_code = cmd.sign_phase ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, stack[0]});
  assign last_char = !cmd.sign_phase && (cnt == CNT_W'(1));

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DIGIT_DEPTH))
    else $error("digit count overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (cnt != '0))
    else $error("pop from empty digit stack");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div |-> (rem_full < VALUE_W'(10)))
    else $error("remainder out of range");

endmodule

// ===== src/signed_int_to_decimal_ascii_core.sv =====
// Each decimal digit takes a reciprocal multiply, then a quotient/remainder step;
//   the first character is offered once the quotient reaches zero.
// Throughput: one character per cycle on the output while dout.ready is high, 1..11 characters per number.
// The next input is taken once the last character of the current number is sent.
// Synchronous active-high reset returns the controller to idle with an empty digit stack.
module signed_int_to_decimal_ascii_core import scid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  scid_in_if.sink    din,
  scid_out_if.source dout
);

  scid_cmd_t    cmd;
  scid_status_t status;

  scid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .status    (status),
    .cmd       (cmd)
  );

  scid_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (din.value),
    .status    (status),
    .char_code (dout.char_code),
    .last_char (dout.last_char)
  );

endmodule

// ===== dv/decimal_text_checker.sv =====
module decimal_text_checker import scid_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  scid_in_if          din,
  scid_out_if         dout,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DECIMAL_BASE = 10;
  localparam int unsigned SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t want;

  // Queue the characters one number should print, leading sign first.
  function automatic void push_decimal_text(logic signed [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits [DIGIT_DEPTH];
    int                 n;
    logic               neg;
    neg = value[VALUE_W-1];
    // unsigned magnitude, so the most negative value stays 2147483648
    mag = neg ? (~value + 1'b1) : value;
    n = 0;
    if (mag == '0) begin
      expected_text.push_back('{code: CHAR_ZERO, last: 1'b1});
      return;
    end
    while (mag != '0) begin
      digits[n] = DIGIT_W'(mag % DECIMAL_BASE);
      mag = mag / DECIMAL_BASE;
      n++;
    end
    if (neg)
      expected_text.push_back('{code: CHAR_MINUS, last: 1'b0});
    for (int i = n - 1; i >= 0; i--)
      expected_text.push_back('{code: CHAR_ZERO + digits[i], last: (i == 0)});
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (dout.valid && dout.ready) begin
        if (expected_text.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: unexpected char 0x%02h last=%0b, nothing pending",
                     $time, dout.char_code, dout.last_char);
        end else begin
          want = expected_text.pop_front();
          if (want.code !== dout.char_code || want.last !== dout.last_char) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
              $display("%0t: char mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       $time, want.code, want.last, dout.char_code, dout.last_char);
          end
        end
      end
      if (din.valid && din.ready)
        push_decimal_text(din.value);
      outstanding = expected_text.size();
    end
  end

endmodule

// ===== dv/signed_int_to_decimal_ascii_core_tb.sv =====
module signed_int_to_decimal_ascii_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_NUMBERS = 130;
  localparam int unsigned IDLE_LIMIT     = 5000;
  localparam int unsigned SETTLE_CYCLES  = 40;

  // receiver stall patterns
  localparam int unsigned RX_STREAM  = 0;
  localparam int unsigned RX_CHOPPY  = 1;
  localparam int unsigned RX_STARVED = 2;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned stall_left;
  int unsigned idle_cycles;

  scid_in_if  din_if ();
  scid_out_if dout_if ();

  signed_int_to_decimal_ascii_core DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  decimal_text_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .din         (din_if),
    .dout        (dout_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    stall_mode = RX_STREAM;
    stall_left = 0;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(RX_STARVED, RX_STREAM);
      stall_left <= $urandom_range(80, 10);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RX_STREAM: dout_if.ready <= 1'b1;
      RX_CHOPPY: dout_if.ready <= ($urandom_range(3, 0) != 0);
      default:   dout_if.ready <= ($urandom_range(4, 0) == 0);
    endcase
  end

  // no transaction on either channel for too long means a hang
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_number(logic signed [31:0] v);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(6, 0);
      if (gap != 0) begin
        din_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(3, 0) == 0) ? 40 : $urandom_range(8, 1);
    end
    din_if.valid <= 1'b1;
    din_if.value <= v;
    do @(posedge clk); while (!din_if.ready);
    burst_left--;
  endtask

  task automatic drain_text();
    @(negedge clk);
    din_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mostly a uniform digit count, with boundaries and raw bit patterns mixed in.
  function automatic logic signed [31:0] random_number();
    int unsigned pick;
    int unsigned n;
    longint      lo;
    longint      hi;
    longint      mag;
    logic        neg;
    pick = $urandom_range(99, 0);
    if (pick < 15)
      return $urandom;
    n = $urandom_range(10, 1);
    lo = 1;
    repeat (n - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (n == 1)
      lo = 0;
    neg = $urandom_range(1, 0);
    if (hi > 64'sd2147483647)
      hi = neg ? 64'sd2147483648 : 64'sd2147483647;
    mag = $urandom_range(int'(hi), int'(lo));
    if (pick < 30)
      mag = $urandom_range(1, 0) ? lo : hi;
    return 32'(neg ? -mag : mag);
  endfunction

  int directed [$] = '{
    0, 1, -1, 9, -9, 10, -10, 99, 100, -5, 12345, -67890,
    999999999, 1000000000, -1000000000, 1234567890,
    2147483647, -2147483647, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
  };

  initial begin
    rst = 1'b1;
    din_if.valid = 1'b0;
    din_if.value = '0;
    dout_if.ready = 1'b0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_number(directed[i]);
    drain_text();

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      send_number(random_number());
      if ($urandom_range(24, 0) == 0)
        drain_text();
    end

    drain_text();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
